@@ sv/tca_pkg.sv @@
// ----------------------------------------------------------------------------
// tca_pkg
// Shared widths, result codes and the sideband type of the triangle
// classifier and Heron area pipeline.
// ----------------------------------------------------------------------------
package tca_pkg;

    localparam int SIDE_BITS = 12;
    localparam int PERIM_W   = SIDE_BITS + 2;
    localparam int AREA_W    = 2 * SIDE_BITS + 1;
    localparam int DIFF_W    = SIDE_BITS + 1;
    localparam int SQ_W      = 2 * SIDE_BITS;
    localparam int SSQ_W     = SQ_W + 1;
    localparam int P1_W      = PERIM_W + DIFF_W;
    localparam int P2_W      = 2 * DIFF_W;
    localparam int PROD_W    = 4 * SIDE_BITS + 2;
    localparam int TRIAL_W   = PROD_W + 1;

    typedef enum logic [2:0] {
        KIND_INVALID     = 3'd0,
        KIND_RIGHT       = 3'd1,
        KIND_EQUILATERAL = 3'd2,
        KIND_ISOSCELES   = 3'd3,
        KIND_OBTUSE      = 3'd4,
        KIND_ACUTE       = 3'd5
    } t_kind;

    typedef struct packed {
        logic               is_valid;
        t_kind              kind;
        logic [PERIM_W-1:0] perimeter;
    } t_side;

endpackage

@@ sv/tca_front.sv @@
// ----------------------------------------------------------------------------
// tca_front
// Four register stages: capture the sides, form the perimeter, the Heron
// factors and the squares, classify and form two partial products, then
// multiply them into the Heron product.
// ----------------------------------------------------------------------------
module tca_front
    import tca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SIDE_BITS-1:0] i_side_a,
    input  logic [SIDE_BITS-1:0] i_side_b,
    input  logic [SIDE_BITS-1:0] i_side_c,
    output logic                 o_valid,
    output logic [PROD_W-1:0]    o_radicand,
    output t_side                o_side
);

    logic                 r_a_vld;
    logic [SIDE_BITS-1:0] r_sa, r_sb, r_sc;

    logic [DIFF_W-1:0]    n_bc, n_ac, n_ab;
    logic                 n_ok;
    logic [PERIM_W-1:0]   n_sum;

    logic                 r_b_vld;
    logic                 r_b_ok;
    logic [PERIM_W-1:0]   r_b_sum;
    logic [DIFF_W-1:0]    r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]      r_aa, r_bb, r_cc;
    logic                 r_eq_ab, r_eq_ac, r_eq_bc;

    logic [SSQ_W-1:0]     n_s_bc, n_s_ac, n_s_ab;
    logic                 n_right, n_obtuse;
    t_kind                n_kind;
    logic [P1_W-1:0]      n_p1;
    logic [P2_W-1:0]      n_p2;

    logic                 r_c_vld;
    t_side                r_c_side;
    logic [P1_W-1:0]      r_p1;
    logic [P2_W-1:0]      r_p2;

    logic                 r_d_vld;
    t_side                r_d_side;
    logic [PROD_W-1:0]    r_prod;

    always_comb begin
        n_bc  = DIFF_W'(r_sb) + DIFF_W'(r_sc);
        n_ac  = DIFF_W'(r_sa) + DIFF_W'(r_sc);
        n_ab  = DIFF_W'(r_sa) + DIFF_W'(r_sb);
        n_sum = PERIM_W'(r_sa) + PERIM_W'(r_sb) + PERIM_W'(r_sc);
        n_ok  = (r_sa != '0) && (r_sb != '0) && (r_sc != '0) &&
                (n_bc > DIFF_W'(r_sa)) && (n_ac > DIFF_W'(r_sb)) &&
                (n_ab > DIFF_W'(r_sc));
    end

    always_comb begin
        n_s_bc   = SSQ_W'(r_bb) + SSQ_W'(r_cc);
        n_s_ac   = SSQ_W'(r_aa) + SSQ_W'(r_cc);
        n_s_ab   = SSQ_W'(r_aa) + SSQ_W'(r_bb);
        n_right  = (SSQ_W'(r_aa) == n_s_bc) || (SSQ_W'(r_bb) == n_s_ac) ||
                   (SSQ_W'(r_cc) == n_s_ab);
        n_obtuse = (SSQ_W'(r_aa) > n_s_bc) || (SSQ_W'(r_bb) > n_s_ac) ||
                   (SSQ_W'(r_cc) > n_s_ab);
        if (!r_b_ok) begin
            n_kind = KIND_INVALID;
        end else if (n_right) begin
            n_kind = KIND_RIGHT;
        end else if (r_eq_ab && r_eq_bc) begin
            n_kind = KIND_EQUILATERAL;
        end else if (r_eq_ab || r_eq_ac || r_eq_bc) begin
            n_kind = KIND_ISOSCELES;
        end else if (n_obtuse) begin
            n_kind = KIND_OBTUSE;
        end else begin
            n_kind = KIND_ACUTE;
        end
        n_p1 = r_b_ok ? P1_W'(r_b_sum) * P1_W'(r_dx) : '0;
        n_p2 = r_b_ok ? P2_W'(r_dy) * P2_W'(r_dz) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa <= i_side_a;
            r_sb <= i_side_b;
            r_sc <= i_side_c;

            r_b_ok  <= n_ok;
            r_b_sum <= n_sum;
            r_dx    <= n_bc - DIFF_W'(r_sa);
            r_dy    <= n_ac - DIFF_W'(r_sb);
            r_dz    <= n_ab - DIFF_W'(r_sc);
            r_aa    <= SQ_W'(r_sa) * SQ_W'(r_sa);
            r_bb    <= SQ_W'(r_sb) * SQ_W'(r_sb);
            r_cc    <= SQ_W'(r_sc) * SQ_W'(r_sc);
            r_eq_ab <= (r_sa == r_sb);
            r_eq_ac <= (r_sa == r_sc);
            r_eq_bc <= (r_sb == r_sc);

            r_c_side.is_valid  <= r_b_ok;
            r_c_side.kind      <= n_kind;
            r_c_side.perimeter <= r_b_sum;
            r_p1               <= n_p1;
            r_p2               <= n_p2;

            r_d_side <= r_c_side;
            r_prod   <= PROD_W'((P1_W + P2_W)'(r_p1) * (P1_W + P2_W)'(r_p2));
        end
    end

    assign o_valid    = r_d_vld;
    assign o_radicand = r_prod;
    assign o_side     = r_d_side;

endmodule

@@ sv/tca_isqrt.sv @@
// ----------------------------------------------------------------------------
// tca_isqrt
// Pipelined integer square root, one result bit per register stage, with
// the classification sideband carried alongside.
// ----------------------------------------------------------------------------
module tca_isqrt
    import tca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [PROD_W-1:0] i_radicand,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [AREA_W-1:0] o_root,
    output t_side             o_side
);

    logic              r_vld  [AREA_W];
    logic [PROD_W-1:0] r_rem  [AREA_W];
    logic [AREA_W-1:0] r_root [AREA_W];
    t_side             r_side [AREA_W];

    for (genvar k = 0; k < AREA_W; k++) begin : g_stage
        localparam int BIT = AREA_W - 1 - k;

        logic              n_vld_in;
        logic [PROD_W-1:0] n_rem_in;
        logic [AREA_W-1:0] n_root_in;
        t_side             n_side_in;
        logic [TRIAL_W-1:0] n_trial;
        logic               n_take;

        if (k == 0) begin : g_first
            assign n_vld_in  = i_valid;
            assign n_rem_in  = i_radicand;
            assign n_root_in = '0;
            assign n_side_in = i_side;
        end else begin : g_next
            assign n_vld_in  = r_vld[k-1];
            assign n_rem_in  = r_rem[k-1];
            assign n_root_in = r_root[k-1];
            assign n_side_in = r_side[k-1];
        end

        always_comb begin
            n_trial = (TRIAL_W'(n_root_in) << (BIT + 1)) +
                      (TRIAL_W'(1) << (2 * BIT));
            n_take  = TRIAL_W'(n_rem_in) >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= n_side_in;
                if (n_take) begin
                    r_rem[k]  <= PROD_W'(TRIAL_W'(n_rem_in) - n_trial);
                    r_root[k] <= n_root_in | (AREA_W'(1) << BIT);
                end else begin
                    r_rem[k]  <= n_rem_in;
                    r_root[k] <= n_root_in;
                end
            end
        end
    end

    assign o_valid = r_vld[AREA_W-1];
    assign o_root  = r_root[AREA_W-1];
    assign o_side  = r_side[AREA_W-1];

endmodule

@@ sv/triangle_classify_area_top.sv @@
// ----------------------------------------------------------------------------
// triangle_classify_area_top
// A triangle passes through the four front stages, then one square-root
// stage per bit of the 25-bit area, before its result appears.
// Throughput: one triangle per cycle; the whole pipeline holds while a
// result waits at the output.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module triangle_classify_area_top
    import tca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SIDE_BITS-1:0] i_side_a,
    input  logic [SIDE_BITS-1:0] i_side_b,
    input  logic [SIDE_BITS-1:0] i_side_c,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_is_valid,
    output logic [2:0]           o_kind,
    output logic [PERIM_W-1:0]   o_perimeter,
    output logic [AREA_W-1:0]    o_area_times_four
);

    logic              w_en;
    logic              w_front_vld;
    logic [PROD_W-1:0] w_radicand;
    t_side             w_front_side;
    t_side             w_out_side;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    tca_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_side_a   (i_side_a),
        .i_side_b   (i_side_b),
        .i_side_c   (i_side_c),
        .o_valid    (w_front_vld),
        .o_radicand (w_radicand),
        .o_side     (w_front_side)
    );

    tca_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_front_vld),
        .i_radicand (w_radicand),
        .i_side     (w_front_side),
        .o_valid    (o_valid),
        .o_root     (o_area_times_four),
        .o_side     (w_out_side)
    );

    assign o_is_valid  = w_out_side.is_valid;
    assign o_kind      = w_out_side.kind;
    assign o_perimeter = w_out_side.perimeter;

endmodule
